// ===== hdl/piu_pkg.sv =====
// Shared types, constants and a helper function for the packed index unpacker.
package piu_pkg;

  localparam int unsigned WORD_BITS      = 64;
  localparam int unsigned ENTRY_COUNT    = 4096;
  localparam int unsigned MAX_ENTRY_BITS = 16;

  localparam int unsigned POS_W   = 13;
  localparam int unsigned POS_OUT = 12;
  localparam int unsigned BITS_W  = 5;
  localparam int unsigned LEFT_W  = 7;
  localparam int unsigned TDATA_W = 32;

  // Configuration register indexes.
  localparam logic CFG_BITS_PER_ENTRY = 1'b0;
  localparam logic CFG_CARRY_MODE     = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CARRY,
    ST_RUN
  } piu_state_e;

  // Low-order mask of n ones, with n from 0 up to MAX_ENTRY_BITS.
  function automatic logic [MAX_ENTRY_BITS-1:0] low_mask(input logic [BITS_W-1:0] n);
    logic [MAX_ENTRY_BITS:0] m;
    m = ({{MAX_ENTRY_BITS{1'b0}}, 1'b1} << n) - {{MAX_ENTRY_BITS{1'b0}}, 1'b1};
    return m[MAX_ENTRY_BITS-1:0];
  endfunction

endpackage

// ===== hdl/packed_index_unpacker_top.sv =====
// Packed index unpacker: one shared barrel shifter stepped by a small sequencer.
// A word is taken in the idle state; its first entry is registered in the output register
// once the sequencer is in the carry or run state. A new word is taken only after the last
// one is unpacked: 64/width entries rounded down, or the joined entry and (64 - width + carried)/width
// more. A full output register that is not taken stalls the sequencer while entries are emitted.
// Reset clears the sequencer, carry and position count; width 4, discard mode.
module packed_index_unpacker_top
  import piu_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write channel.
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [BITS_W-1:0]          cfg_data_i,
  // Input word stream.
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [WORD_BITS-1:0]       s_axis_tdata_i,   // [63:0] data_word
  input  logic                       s_axis_tuser_i,   // [0] first_word
  // Output entry stream.
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [TDATA_W-1:0]         m_axis_tdata_o,   // [15:0] entry_value,
                                                       // [27:16] entry_position, zero pad
  output logic                       m_axis_tlast_o    // last_of_word
);

  piu_state_e state_q, state_d;

  logic [BITS_W-1:0]         bits_cfg_q;
  logic                      carry_cfg_q;
  logic [WORD_BITS-1:0]      word_q;
  logic [LEFT_W-1:0]         left_q;
  logic [MAX_ENTRY_BITS-1:0] carried_q;
  logic [BITS_W-1:0]         carried_cnt_q;
  logic [POS_W-1:0]          pos_q;

  logic                      out_valid_q;
  logic [MAX_ENTRY_BITS-1:0] out_value_q;
  logic [POS_OUT-1:0]        out_pos_q;
  logic                      out_last_q;

  logic                      accept;
  logic [BITS_W-1:0]         width;
  logic [MAX_ENTRY_BITS-1:0] mask;
  logic [BITS_W-1:0]         cnt_eff;
  logic [POS_W-1:0]          pos_eff;
  logic [BITS_W-1:0]         shamt;
  logic [WORD_BITS-1:0]      shifted;
  logic [LEFT_W-1:0]         left_next;
  logic                      emit_ok;
  logic                      step;
  logic                      word_done;
  logic [MAX_ENTRY_BITS-1:0] joined;
  logic [MAX_ENTRY_BITS-1:0] entry;

  assign cfg_ready_o     = 1'b1;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign width           = (bits_cfg_q > BITS_W'(MAX_ENTRY_BITS)) ?
                           BITS_W'(MAX_ENTRY_BITS) : bits_cfg_q;
  assign mask            = low_mask(width);
  assign cnt_eff         = s_axis_tuser_i ? '0 : carried_cnt_q;
  assign pos_eff         = s_axis_tuser_i ? '0 : pos_q;

  // The one shifter: it drops the bits that completed the carried entry, or one entry.
  assign shamt     = (state_q == ST_CARRY) ? (width - carried_cnt_q) : width;
  assign shifted   = word_q >> shamt;
  assign left_next = left_q - LEFT_W'(shamt);

  assign emit_ok   = pos_q < POS_W'(ENTRY_COUNT);
  assign step      = (state_q != ST_IDLE) && (!emit_ok || !out_valid_q || m_axis_tready_i);
  assign word_done = (state_q == ST_RUN) && (left_next < LEFT_W'(width));

  assign joined = (word_q[MAX_ENTRY_BITS-1:0] << carried_cnt_q) | carried_q;
  assign entry  = ((state_q == ST_CARRY) ? joined : word_q[MAX_ENTRY_BITS-1:0]) & mask;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && width != '0) begin
          state_d = (cnt_eff != '0 && cnt_eff < width) ? ST_CARRY : ST_RUN;
        end
      end
      ST_CARRY: begin
        if (step) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step && word_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE:  s_axis_tready_o = 1'b1;
      ST_CARRY: s_axis_tready_o = 1'b0;
      ST_RUN:   s_axis_tready_o = 1'b0;
      default:  s_axis_tready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      bits_cfg_q    <= BITS_W'(4);
      carry_cfg_q   <= 1'b0;
      carried_q     <= '0;
      carried_cnt_q <= '0;
      pos_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_BITS_PER_ENTRY: bits_cfg_q  <= cfg_data_i;
          CFG_CARRY_MODE:     carry_cfg_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (accept) begin
        pos_q <= pos_eff;
        if (width == '0 || s_axis_tuser_i) begin
          carried_q     <= '0;
          carried_cnt_q <= '0;
        end
      end

      if (step && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      if (step) begin
        if (emit_ok) begin
          pos_q <= pos_q + POS_W'(1);
        end
        // At the end of a word the leftover top bits are kept or thrown away.
        if (word_done) begin
          if (carry_cfg_q && left_next != '0) begin
            carried_q     <= shifted[MAX_ENTRY_BITS-1:0] & low_mask(left_next[BITS_W-1:0]);
            carried_cnt_q <= left_next[BITS_W-1:0];
          end else begin
            carried_q     <= '0;
            carried_cnt_q <= '0;
          end
        end
      end
    end
  end

  // Datapath and payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= s_axis_tdata_i;
      left_q <= LEFT_W'(WORD_BITS);
    end else if (step) begin
      word_q <= shifted;
      left_q <= left_next;
    end
    if (step && emit_ok) begin
      out_value_q <= entry;
      out_pos_q   <= pos_q[POS_OUT-1:0];
      // The last beat of a word is its final entry, or the one that fills the section.
      out_last_q  <= word_done || (pos_q == POS_W'(ENTRY_COUNT - 1));
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(TDATA_W - MAX_ENTRY_BITS - POS_OUT){1'b0}}, out_pos_q, out_value_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
